/* hdl/deq_pkg.sv */
// shared types, constants and ring helpers for the double-ended queue
`default_nettype none
package deq_pkg;

	// storage geometry
	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = IDX_W + 1;
	localparam int OCC_W = 5;
	localparam int WORD_W = 32;

	// operation codes
	localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [2:0] KIND_PUSH_REAR  = 3'd1;
	localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [2:0] KIND_POP_REAR   = 3'd3;
	localparam logic [2:0] KIND_PEEK       = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]               kind;
		logic signed [WORD_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] popped;
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] rear_value;
		logic [OCC_W-1:0]         occupancy;
	} result_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
		logic fetch;
	} dp_cmd_t;

	// count widened to the ring sum width
	function automatic logic [SUM_W-1:0] cnt_to_sum(input logic [CNT_W-1:0] c);
		logic [SUM_W+CNT_W-1:0] wide;
		wide = {{SUM_W{1'b0}}, c};
		return wide[SUM_W-1:0];
	endfunction

	// base plus offset modulo depth, offset at most depth
	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
			input logic [SUM_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = {1'b0, base} + off;
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* hdl/deq_ctrl.sv */
// sequencing state machine for the double-ended queue
`default_nettype none
module deq_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	output logic                done,
	output deq_pkg::dp_cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_OP,
		S_READ,
		S_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   done_q;
	logic   accept;

	// a beat is taken while idle or while the last result is shown
	assign accept = start && !busy_q;

	always_comb begin
		case (state_q)
			S_IDLE:  state_d = accept ? S_OP : S_IDLE;
			S_OP:    state_d = S_READ;
			S_READ:  state_d = S_OUT;
			S_OUT:   state_d = accept ? S_OP : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// state and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d == S_OP) || (state_d == S_READ);
			done_q  <= (state_d == S_OUT);
		end
	end

	// datapath commands
	always_comb begin
		cmd.load  = accept;
		cmd.exec  = (state_q == S_OP);
		cmd.fetch = (state_q == S_READ);
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule
`default_nettype wire

/* hdl/deq_dp.sv */
// ring storage, pointers and result registers of the double-ended queue
`default_nettype none
module deq_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire deq_pkg::dp_cmd_t  cmd,
	input  wire deq_pkg::item_t    item,
	output deq_pkg::result_t       result
);

	localparam int IDX_W = deq_pkg::IDX_W;
	localparam int CNT_W = deq_pkg::CNT_W;
	localparam int OCC_W = deq_pkg::OCC_W;
	localparam int WORD_W = deq_pkg::WORD_W;

	logic [WORD_W-1:0] slots [deq_pkg::DEPTH];

	deq_pkg::item_t    item_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic              pop_ok_q;
	logic [1:0]        status_q;
	logic [WORD_W-1:0] popped_q;
	logic [WORD_W-1:0] rd_a_q;
	logic [WORD_W-1:0] rd_b_q;

	logic              empty;
	logic              full;
	logic [IDX_W-1:0]  head_d;
	logic [CNT_W-1:0]  count_d;
	logic [1:0]        status_d;
	logic              pop_ok_d;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [IDX_W-1:0]  pop_addr;
	logic [IDX_W-1:0]  rear_addr;
	logic [IDX_W-1:0]  rd_a_addr;
	logic [IDX_W-1:0]  head_dec;
	logic [IDX_W-1:0]  head_inc;
	logic [CNT_W-1:0]  count_m1;
	logic [OCC_W+CNT_W-1:0] occ_wide;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(deq_pkg::DEPTH));
	assign count_m1 = empty ? '0 : count_q - CNT_W'(1);
	assign head_dec = (head_q == '0) ? IDX_W'(deq_pkg::DEPTH - 1) : head_q - IDX_W'(1);
	assign head_inc = (head_q == IDX_W'(deq_pkg::DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
	assign rear_addr = deq_pkg::ring_add(head_q, deq_pkg::cnt_to_sum(count_m1));

	// operation decode on current pointers
	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		status_d = deq_pkg::ST_OK;
		pop_ok_d = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = head_q;
		pop_addr = head_q;
		case (item_q.kind)
			deq_pkg::KIND_PUSH_FRONT: begin
				if (full) begin
					status_d = deq_pkg::ST_FULL;
				end else begin
					head_d  = head_dec;
					wr_addr = head_dec;
					wr_en   = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			deq_pkg::KIND_PUSH_REAR: begin
				if (full) begin
					status_d = deq_pkg::ST_FULL;
				end else begin
					wr_addr = deq_pkg::ring_add(head_q, deq_pkg::cnt_to_sum(count_q));
					wr_en   = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			deq_pkg::KIND_POP_FRONT: begin
				if (empty) begin
					status_d = deq_pkg::ST_EMPTY;
				end else begin
					pop_addr = head_q;
					pop_ok_d = 1'b1;
					head_d   = head_inc;
					count_d  = count_m1;
				end
			end
			deq_pkg::KIND_POP_REAR: begin
				if (empty) begin
					status_d = deq_pkg::ST_EMPTY;
				end else begin
					pop_addr = rear_addr;
					pop_ok_d = 1'b1;
					count_d  = count_m1;
				end
			end
			default: begin
				status_d = empty ? deq_pkg::ST_EMPTY : deq_pkg::ST_OK;
			end
		endcase
	end

	// popped word during the operation, front word afterwards
	assign rd_a_addr = cmd.exec ? pop_addr : head_q;

	// ring storage with registered reads
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			slots[wr_addr] <= item_q.value;
		end
		rd_a_q <= slots[rd_a_addr];
		rd_b_q <= slots[rear_addr];
	end

	// pointers and per-item control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			pop_ok_q <= 1'b0;
		end else if (cmd.exec) begin
			head_q   <= head_d;
			count_q  <= count_d;
			pop_ok_q <= pop_ok_d;
		end
	end

	// input beat and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.exec) begin
			status_q <= status_d;
		end
		if (cmd.fetch) begin
			popped_q <= pop_ok_q ? rd_a_q : '0;
		end
	end

	assign occ_wide = {{OCC_W{1'b0}}, count_q};

	always_comb begin
		result.status      = status_q;
		result.popped      = popped_q;
		result.front_value = empty ? '0 : rd_a_q;
		result.rear_value  = empty ? '0 : rd_b_q;
		result.occupancy   = occ_wide[OCC_W-1:0];
	end

endmodule
`default_nettype wire

/* hdl/double_ended_queue_unit.sv */
// top level of the bounded double-ended queue
//
//   channel   handshake            payload
//   input     start / busy         item   (deq_pkg::item_t)
//   result    done (one cycle)     result (deq_pkg::result_t)
//
// an item passes the operation state with ring write or pop read, then the
// front/rear read of the two-port storage, then the output state with done high
// busy is low while idle and while a result is shown, so a new beat can be
// taken in the done cycle
// reset clears head and count; the storage itself is not cleared
// the receiver cannot stall: each result is shown for exactly one cycle
`default_nettype none
module double_ended_queue_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire deq_pkg::item_t    item,
	output logic                   done,
	output deq_pkg::result_t       result
);

	deq_pkg::dp_cmd_t cmd;

	// sequencing
	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// storage and pointers
	deq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.result (result)
	);

endmodule
`default_nettype wire
